>>> sv/agkf_pkg.sv
// Package for the angle/gyro Kalman filter: fixed-point formats, reset values,
// register indexes and a shared saturation helper. No dependencies.
package agkf_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned CfgW  = 31;
    localparam int unsigned FracQ = 28;
    localparam int unsigned IdxW  = 2;

    typedef logic signed [DataW-1:0] t_word;
    typedef logic        [CfgW-1:0]  t_cfg;
    typedef logic        [IdxW-1:0]  t_cfg_idx;

    localparam t_cfg_idx RegTimeStep    = 2'd0;
    localparam t_cfg_idx RegAngleNoise  = 2'd1;
    localparam t_cfg_idx RegBiasNoise   = 2'd2;
    localparam t_cfg_idx RegMeasureNoise = 2'd3;

    localparam t_cfg  RstTimeStep     = 31'd268435;
    localparam t_cfg  RstAngleNoise   = 31'd268435;
    localparam t_cfg  RstBiasNoise    = 31'd1342177;
    localparam t_cfg  RstMeasureNoise = 31'd13421773;
    localparam t_word OneQ28          = 32'sd268435456;

    // Clamp a 34-bit signed value to 32 bits.
    function automatic t_word sat34(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

>>> sv/angle_gyro_kalman_filter.sv
// Two-state angle / gyro-bias Kalman filter, top level.
// Depends on agkf_pkg and agkf_div (serial gain divider).
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  input   | i_valid, o_stall, i_angle_meas, i_rate_meas | in
//  output  | o_valid, i_stall, o_angle_est, o_rate_est   | out
//  config  | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | in
//
// A sequencer runs 10 products through one shared 32x32 multiplier (one
// product per cycle while it steps, registered) and two divisions through
// the serial divider.
// Reset restores the configuration and the filter state at once.
// The input stalls while an item is in work. A result that waits on the output
// holds the next item in its last step until the output transfer.
module angle_gyro_kalman_filter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  agkf_pkg::t_word       i_angle_meas,
    input  agkf_pkg::t_word       i_rate_meas,
    output logic                  o_valid,
    input  logic                  i_stall,
    output agkf_pkg::t_word       o_angle_est,
    output agkf_pkg::t_word       o_rate_est,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);
    import agkf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_RATE, S_AP, S_PD, S_PAA, S_PAB, S_PBB, S_DIV0, S_WAIT0,
        S_DIV1, S_WAIT1, S_ANG, S_BIAS, S_CAA, S_CAB, S_CBA, S_CBB, S_OUT
    } t_state;

    t_state r_state;
    t_cfg   r_dt, r_qa, r_qb, r_rm;
    t_word  r_ang, r_bias, r_caa, r_cab, r_cba, r_cbb;
    t_word  r_am, r_gm, r_rate, r_ap, r_y, r_paa, r_pab, r_pba, r_pbb;
    t_word  r_k0, r_k1;
    logic   r_ovalid;

    // shared multiplier: operands chosen by state, product registered
    t_word              w_ma, w_mb;
    logic signed [63:0] r_prod;
    logic signed [64:0] w_rnd;
    logic signed [36:0] w_sh;
    t_word              w_m;
    logic               r_pv;

    logic                w_div_start;
    t_word               w_div_num;
    logic signed [32:0]  w_den;
    logic                w_div_done;
    t_word               w_quot;

    always_comb begin
        w_ma = r_rate;
        w_mb = t_word'({1'b0, r_dt});
        case (r_state)
            S_RATE:  begin w_ma = r_rate; w_mb = t_word'({1'b0, r_dt}); end
            S_PD:    begin w_ma = r_paa;  w_mb = t_word'({1'b0, r_dt}); end
            S_PAA:   begin w_ma = r_cbb;  w_mb = t_word'({1'b0, r_dt}); end
            S_PAB:   begin w_ma = t_word'({1'b0, r_qb}); w_mb = t_word'({1'b0, r_dt}); end
            S_WAIT1: begin w_ma = r_y;    w_mb = r_k0; end
            S_ANG:   begin w_ma = r_y;    w_mb = r_k1; end
            S_BIAS:  begin w_ma = r_paa;  w_mb = r_k0; end
            S_CAA:   begin w_ma = r_pab;  w_mb = r_k0; end
            S_CAB:   begin w_ma = r_paa;  w_mb = r_k1; end
            S_CBA:   begin w_ma = r_pab;  w_mb = r_k1; end
            default: ;
        endcase
        w_rnd = 65'(r_prod) + 65'sd134217728;
        w_sh  = 37'(w_rnd >>> FracQ);
        if (w_sh > 37'sh0_7FFF_FFFF) begin
            w_m = 32'sh7FFF_FFFF;
        end else if (w_sh < -37'sh0_8000_0000) begin
            w_m = 32'sh8000_0000;
        end else begin
            w_m = w_sh[31:0];
        end
    end

    assign w_den       = 33'(r_paa) + 33'($signed({2'b0, r_rm}));
    assign w_div_start = (r_state == S_DIV0) || (r_state == S_DIV1);
    assign w_div_num   = (r_state == S_DIV0) ? r_paa : r_pba;

    agkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid     = r_ovalid;

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
            r_dt     <= RstTimeStep;
            r_qa     <= RstAngleNoise;
            r_qb     <= RstBiasNoise;
            r_rm     <= RstMeasureNoise;
            r_ang    <= '0;
            r_bias   <= '0;
            r_caa    <= OneQ28;
            r_cab    <= '0;
            r_cba    <= '0;
            r_cbb    <= OneQ28;
        end else begin
            r_pv <= (r_state != S_IDLE);
            if ((r_state == S_OUT) && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    3'(RegTimeStep):     r_dt <= i_cfg_data[30:0];
                    3'(RegAngleNoise):   r_qa <= i_cfg_data[30:0];
                    3'(RegBiasNoise):    r_qb <= i_cfg_data[30:0];
                    3'(RegMeasureNoise): r_rm <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            // each state that uses a product consumes the one issued by the state before it
            case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_am    <= i_angle_meas;
                        r_gm    <= i_rate_meas;
                        r_rate  <= sat34(34'(i_rate_meas) - 34'(r_bias));
                        r_paa   <= sat34(34'($signed({3'b0, r_qa})) - 34'(r_cab)
                                         - 34'(r_cba));
                        r_state <= S_RATE;
                    end
                end
                S_RATE: r_state <= S_AP;
                S_AP: begin
                    r_ap    <= sat34(34'(r_ang) + 34'(w_m));
                    r_state <= S_PD;
                end
                S_PD: begin
                    r_y     <= sat34(34'(r_am) - 34'(r_ap));
                    r_state <= S_PAA;
                end
                S_PAA: begin
                    r_paa   <= sat34(34'(r_caa) + 34'(w_m));
                    r_state <= S_PAB;
                end
                S_PAB: begin
                    r_pab   <= sat34(34'(r_cab) - 34'(w_m));
                    r_pba   <= sat34(34'(r_cba) - 34'(w_m));
                    r_state <= S_PBB;
                end
                S_PBB: begin
                    r_pbb   <= sat34(34'(r_cbb) + 34'(w_m));
                    r_state <= S_DIV0;
                end
                S_DIV0: r_state <= S_WAIT0;
                S_WAIT0: if (w_div_done) begin
                    r_k0    <= w_quot;
                    r_state <= S_DIV1;
                end
                S_DIV1: r_state <= S_WAIT1;
                S_WAIT1: if (w_div_done) begin
                    r_k1    <= w_quot;
                    r_state <= S_ANG;
                end
                S_ANG: begin
                    r_ang   <= sat34(34'(r_ap) + 34'(w_m));
                    r_state <= S_BIAS;
                end
                S_BIAS: begin
                    r_bias  <= sat34(34'(r_bias) + 34'(w_m));
                    r_state <= S_CAA;
                end
                S_CAA: begin
                    r_caa   <= sat34(34'(r_paa) - 34'(w_m));
                    r_state <= S_CAB;
                end
                S_CAB: begin
                    r_cab   <= sat34(34'(r_pab) - 34'(w_m));
                    r_state <= S_CBA;
                end
                S_CBA: begin
                    r_cba   <= sat34(34'(r_pba) - 34'(w_m));
                    r_state <= S_CBB;
                end
                S_CBB: begin
                    r_cbb   <= sat34(34'(r_pbb) - 34'(w_m));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold while the previous result still waits on the output
                    if (!r_ovalid || !i_stall) begin
                        o_angle_est <= r_ang;
                        o_rate_est  <= sat34(34'(r_gm) - 34'(r_bias));
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> r_ovalid) else $error("result lost");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> (r_state == S_IDLE)) else $error("config while busy");
    a_pv_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ANG) |-> r_pv) else $error("product not ready");

endmodule

>>> sv/agkf_div.sv
// Serial restoring divider for the gain: q = trunc(p * 2^28 / s), saturated.
// Depends on agkf_pkg. One quotient bit per cycle.
module agkf_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  agkf_pkg::t_word      i_num,
    input  logic signed [32:0]   i_den,
    output logic                 o_done,
    output agkf_pkg::t_word      o_quot
);
    import agkf_pkg::*;

    localparam int unsigned NumW = 60;  // |p| * 2^28 fits in 60 bits
    localparam int unsigned CntW = 6;

    logic [NumW-1:0] r_num, n_num;
    logic [32:0]     r_den;
    logic [NumW-1:0] r_quo, n_quo;
    logic [33:0]     r_rem, n_rem;
    logic [CntW-1:0] r_cnt;
    logic            r_busy;
    logic            r_neg;
    logic            r_zero;
    logic [33:0]     w_trial;
    logic [NumW-1:0] w_mag;
    logic [NumW:0]   w_sq;

    always_comb begin
        n_rem   = {r_rem[32:0], r_num[NumW-1]};
        n_num   = {r_num[NumW-2:0], 1'b0};
        w_trial = n_rem - {1'b0, r_den};
        n_quo   = {r_quo[NumW-2:0], ~w_trial[33]};
        if (!w_trial[33]) begin
            n_rem = w_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(NumW);
                r_rem  <= '0;
                r_quo  <= '0;
                r_zero <= (i_den == '0);
                r_neg  <= i_num[31] ^ i_den[32];
                r_den  <= i_den[32] ? 33'(-i_den) : 33'(i_den);
                r_num  <= {(i_num[31] ? 32'(-33'(i_num)) : 32'(i_num)), 28'd0};
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= n_num;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        w_mag = r_quo;
        w_sq  = r_neg ? -{1'b0, w_mag} : {1'b0, w_mag};
        if (r_zero) begin
            o_quot = '0;
        end else if (!r_neg && (w_mag > 60'h0000_0007FFF_FFFF)) begin
            o_quot = 32'sh7FFF_FFFF;
        end else if (r_neg && (w_mag > 60'h0000_0008000_0000)) begin
            o_quot = 32'sh8000_0000;
        end else begin
            o_quot = w_sq[31:0];
        end
    end

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("divider done held");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("divider did not start");
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0) else $error("divider count underflow");

endmodule

>>> tb/angle_gyro_kalman_filter_tb.sv
// Self-checking testbench for angle_gyro_kalman_filter: directed and random
// sensor samples, register settings between phases. Depends on agkf_pkg.
module angle_gyro_kalman_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import agkf_pkg::*;

    localparam int         IdleLimit = 20000;
    localparam int         LongHold  = 600;
    localparam logic [2:0] IdxUnused = 3'd5;

    typedef struct {
        t_word angle;
        t_word rate;
    } t_estimate;

    typedef struct {
        t_word angle;
        t_word rate;
        bit    typed;
        t_word exp_angle;
        t_word exp_rate;
    } t_sample_row;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_stall;
    t_word i_angle_meas = '0;
    t_word i_rate_meas = '0;
    logic  o_valid;
    logic  i_stall = 1'b1;
    t_word o_angle_est;
    t_word o_rate_est;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    angle_gyro_kalman_filter DUT (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Filter state and register copies
    int dt_q, qa_q, qb_q, r_q;
    int est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;

    t_estimate expected_estimates[$];
    int        mismatches = 0;
    int        samples_sent = 0;
    int        estimates_seen = 0;
    int        cfg_writes = 0;
    int        idle_cycles = 0;
    bit        held_off = 1'b0;

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic int qmul(int x, int q);
        longint p;
        p = longint'(x) * longint'(q) + (64'sd1 <<< 27);
        return clamp32(p >>> 28);
    endfunction

    function automatic int kgain(int p, longint s);
        if (s == 0) return 0;
        return clamp32((longint'(p) <<< 28) / s);
    endfunction

    task automatic filter_reset();
        dt_q = int'(RstTimeStep);
        qa_q = int'(RstAngleNoise);
        qb_q = int'(RstBiasNoise);
        r_q  = int'(RstMeasureNoise);
        est_angle = 0;
        est_bias = 0;
        p_aa = OneQ28;
        p_ab = 0;
        p_ba = 0;
        p_bb = OneQ28;
    endtask

    function automatic t_estimate filter_step(t_word am, t_word gm);
        int rate, ap, y, pd, paa, pab, pba, pbb, k0, k1;
        longint s;
        t_estimate e;
        rate = clamp32(longint'(gm) - est_bias);
        ap   = clamp32(longint'(est_angle) + qmul(rate, dt_q));
        y    = clamp32(longint'(am) - ap);
        pd   = clamp32(longint'(qa_q) - p_ab - p_ba);
        paa  = clamp32(longint'(p_aa) + qmul(pd, dt_q));
        pab  = clamp32(longint'(p_ab) - qmul(p_bb, dt_q));
        pba  = clamp32(longint'(p_ba) - qmul(p_bb, dt_q));
        pbb  = clamp32(longint'(p_bb) + qmul(qb_q, dt_q));
        s    = longint'(paa) + longint'(r_q);
        k0   = kgain(paa, s);
        k1   = kgain(pba, s);
        est_angle = clamp32(longint'(ap) + qmul(y, k0));
        est_bias  = clamp32(longint'(est_bias) + qmul(y, k1));
        p_aa = clamp32(longint'(paa) - qmul(paa, k0));
        p_ab = clamp32(longint'(pab) - qmul(pab, k0));
        p_ba = clamp32(longint'(pba) - qmul(paa, k1));
        p_bb = clamp32(longint'(pbb) - qmul(pab, k1));
        e.angle = est_angle;
        e.rate  = clamp32(longint'(gm) - est_bias);
        return e;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(80, 20);
    endfunction

    // Offer one sample and hold it until the transfer; keep valid high when
    // no gap follows.
    task automatic send_sample(t_word am, t_word gm, bit typed, t_estimate typed_est);
        t_estimate e;
        int gap;
        i_valid <= 1'b1;
        i_angle_meas <= am;
        i_rate_meas <= gm;
        do @(posedge i_clk); while (o_stall);
        e = filter_step(am, gm);
        expected_estimates.push_back(typed ? typed_est : e);
        samples_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            {1'b0, RegTimeStep}:     dt_q = int'(data[30:0]);
            {1'b0, RegAngleNoise}:   qa_q = int'(data[30:0]);
            {1'b0, RegBiasNoise}:    qb_q = int'(data[30:0]);
            {1'b0, RegMeasureNoise}: r_q  = int'(data[30:0]);
            default: ;
        endcase
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_estimates.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic configure(logic [31:0] dt, logic [31:0] qa, logic [31:0] qb,
                             logic [31:0] rm);
        write_reg({1'b0, RegTimeStep}, dt);
        write_reg({1'b0, RegAngleNoise}, qa);
        write_reg({1'b0, RegBiasNoise}, qb);
        write_reg({1'b0, RegMeasureNoise}, rm);
    endtask

    function automatic logic [31:0] pick_small(int top);
        return $urandom_range(top);
    endfunction

    // Check each estimate against the oldest one predicted
    always @(posedge i_clk) begin
        t_estimate e;
        if (i_rst_n && o_valid && !i_stall) begin
            estimates_seen++;
            if (expected_estimates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected estimate angle=%0d rate=%0d", o_angle_est, o_rate_est);
            end else begin
                e = expected_estimates.pop_front();
                if (o_angle_est !== e.angle || o_rate_est !== e.rate) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("estimate %0d: angle exp %0d got %0d, rate exp %0d got %0d",
                                 estimates_seen, e.angle, o_angle_est, e.rate, o_rate_est);
                end
            end
        end
    end

    // Receiver stall: mostly short, one long hold-off early in the random part
    initial begin
        int burst;
        burst = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!held_off && samples_sent >= 40) begin
                held_off = 1'b1;
                i_stall <= 1'b1;
                repeat (LongHold) @(posedge i_clk);
            end
            if (burst > 0) begin
                burst--;
                i_stall <= 1'b1;
            end else begin
                int roll;
                roll = $urandom_range(99);
                if (roll < 60) begin
                    i_stall <= 1'b0;
                end else if (roll < 95) begin
                    burst = $urandom_range(3);
                    i_stall <= 1'b1;
                end else begin
                    burst = $urandom_range(60, 15);
                    i_stall <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    t_sample_row directed_rows[] = '{
        '{32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0},
        '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 32'sd0, 32'sd0},
        '{32'sh8000_0000, 32'sh8000_0000, 1'b0, 32'sd0, 32'sd0},
        '{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 32'sd0, 32'sd0},
        '{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 32'sd0, 32'sd0},
        '{32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, 32'sd0, 32'sd0},
        '{32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, 32'sd0, 32'sd0},
        '{32'sd0, 32'sh8000_0000, 1'b0, 32'sd0, 32'sd0},
        '{32'sd655360, 32'sd65536, 1'b0, 32'sd0, 32'sd0},
        '{32'sd655360, -32'sd65536, 1'b0, 32'sd0, 32'sd0},
        '{-32'sd1, 32'sd1, 1'b0, 32'sd0, 32'sd0},
        '{32'sd1, -32'sd1, 1'b0, 32'sd0, 32'sd0}
    };

    initial begin
        t_estimate te;
        int phase_len;
        t_word angle_walk;
        filter_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            te.angle = directed_rows[i].exp_angle;
            te.rate  = directed_rows[i].exp_rate;
            send_sample(directed_rows[i].angle, directed_rows[i].rate,
                        directed_rows[i].typed, te);
        end
        drain();

        // Zero innovation variance: unit gain empties Paa, then dt = 0 keeps it empty
        configure(32'd0, 32'd0, 32'd0, 32'd0);
        write_reg(IdxUnused, 32'hFFFF_FFFF);
        repeat (4) send_sample($urandom, $urandom, 1'b0, te);
        drain();

        // Extremes of every register, data bit 31 set to be masked off
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (6) send_sample($urandom, $urandom, 1'b0, te);
        drain();

        for (int ph = 0; ph < 11; ph++) begin
            if (ph == 0)
                configure(32'(RstTimeStep), 32'(RstAngleNoise), 32'(RstBiasNoise),
                          32'(RstMeasureNoise));
            else if (ph % 4 == 3)
                configure($urandom, $urandom, $urandom, $urandom);
            else
                configure(pick_small(2000000), pick_small(2000000), pick_small(8000000),
                          pick_small(60000000));
            phase_len = $urandom_range(110, 90);
            angle_walk = $urandom_range(5898240) - 2949120;
            for (int n = 0; n < phase_len; n++) begin
                if ($urandom_range(9) < 8) begin
                    // plausible sensor track: slow angle drift, modest rate
                    angle_walk = angle_walk + $signed($urandom_range(131072)) - 65536;
                    send_sample(angle_walk + $signed($urandom_range(32768)) - 16384,
                                $signed($urandom_range(26214400)) - 13107200, 1'b0, te);
                end else begin
                    send_sample($urandom, $urandom, 1'b0, te);
                end
            end
            drain();
        end

        repeat (200) @(posedge i_clk);
        $display("Covered %0d samples, %0d estimates, %0d register writes, %0d mismatches.",
                 samples_sent, estimates_seen, cfg_writes, mismatches);
        if (mismatches == 0 && expected_estimates.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
